// File: src/bta_pkg.sv
// Shared types and constants for the boundary-tag first-fit allocator.
`timescale 1ns / 1ps

package bta_pkg;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_FIT_CHK,
        ST_FIT_EVAL,
        ST_GROW,
        ST_GROW_W0,
        ST_GROW_W1,
        ST_GROW_W2,
        ST_MRG_RP,
        ST_MRG_PE,
        ST_MRG_NE,
        ST_MRG_W0,
        ST_MRG_W1,
        ST_CRV_W0,
        ST_CRV_W1,
        ST_CRV_W2,
        ST_CRV_W3,
        ST_LIV_CHK,
        ST_LIV_EVAL,
        ST_REL_W0,
        ST_REL_W1,
        ST_RESP
    } state_t;

    localparam logic       KIND_ALLOC   = 1'b0;
    localparam logic       KIND_RELEASE = 1'b1;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_ZERO = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    localparam int OFF_W  = 18;
    localparam int REQ_W  = 19;
    localparam int STAT_W = 2;

    localparam int FIRST_PAYLOAD = 16;
    localparam int MIN_SPLIT     = 16;
    localparam int INIT_CHUNK    = 4096;
    localparam int INIT_BREAK    = 4112;
    localparam int INIT_LAST     = 5;

endpackage

// File: src/bta_tag_ram.sv
// Tag memory: one write port, one registered read port.
`timescale 1ns / 1ps

module bta_tag_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int DW    = 19
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/bta_seq.sv
// Sequencer: block walk, heap growth, coalescing and splitting over the tag memory.
`timescale 1ns / 1ps

module bta_seq #(
    parameter int HEAP_WORDS  = 65536,
    parameter int CHUNK_BYTES = 4096,
    parameter int WAW         = 16,
    parameter int BW          = 19
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_kind,
    input  logic [bta_pkg::REQ_W-1:0]   in_req,
    input  logic [bta_pkg::OFF_W-1:0]   in_off,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic [bta_pkg::OFF_W-1:0]   res_off,
    output logic [bta_pkg::STAT_W-1:0]  res_stat,
    output logic                        mem_we,
    output logic [WAW-1:0]              mem_waddr,
    output logic [BW-1:0]               mem_wdata,
    output logic [WAW-1:0]              mem_raddr,
    input  logic [BW-1:0]               mem_rdata
);

    import bta_pkg::*;

    localparam int WW         = ((BW > 20) ? BW : 20) + 1;
    localparam int CHUNK_WDS  = CHUNK_BYTES / 4;
    localparam int GROW_MIN_I = (CHUNK_WDS + (CHUNK_WDS % 2)) * 4;
    localparam logic [WW-1:0] GROW_MIN   = WW'(GROW_MIN_I);
    localparam logic [WW-1:0] CHUNK_W    = WW'(CHUNK_BYTES);
    localparam logic [WW-1:0] HEAP_BYTES = WW'(HEAP_WORDS * 4);

    state_t state_reg, state_next;

    logic [2:0]        init_cnt_reg, init_cnt_next;
    logic              kind_reg, kind_next;
    logic [WW-1:0]     need_reg, need_next;
    logic [WW-1:0]     off_reg, off_next;
    logic [WW-1:0]     bp_reg, bp_next;
    logic [WW-1:0]     brk_reg, brk_next;
    logic [WW-1:0]     own_reg, own_next;
    logic [WW-1:0]     total_reg, total_next;
    logic [WW-1:0]     psz_reg, psz_next;
    logic              pfree_reg, pfree_next;
    logic [WW-1:0]     hdr_reg, hdr_next;
    logic [WW-1:0]     ftr_reg, ftr_next;
    logic [WW-1:0]     asz_reg, asz_next;
    logic              split_reg, split_next;
    logic [OFF_W-1:0]  res_off_reg, res_off_next;
    logic [STAT_W-1:0] stat_reg, stat_next;

    logic [WW-1:0] rd_sz;
    logic          rd_alloc;
    logic [WW-1:0] grow;
    logic          full;
    logic          fits;
    logic          split_now;
    logic [WW-1:0] nsz;

    function automatic logic [WAW-1:0] wa(input logic [WW-1:0] b);
        return b[WAW+1:2];
    endfunction

    assign rd_sz     = WW'({mem_rdata[BW-1:3], 3'b000});
    assign rd_alloc  = mem_rdata[0];
    assign grow      = (need_reg > CHUNK_W) ? need_reg : GROW_MIN;
    assign full      = (brk_reg + grow) > HEAP_BYTES;
    assign fits      = !rd_alloc && (rd_sz >= need_reg);
    assign split_now = total_reg >= (need_reg + WW'(MIN_SPLIT));
    assign nsz       = rd_alloc ? '0 : rd_sz;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            init_cnt_reg <= '0;
            brk_reg      <= WW'(INIT_BREAK);
        end else begin
            state_reg    <= state_next;
            init_cnt_reg <= init_cnt_next;
            brk_reg      <= brk_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        need_reg    <= need_next;
        off_reg     <= off_next;
        bp_reg      <= bp_next;
        own_reg     <= own_next;
        total_reg   <= total_next;
        psz_reg     <= psz_next;
        pfree_reg   <= pfree_next;
        hdr_reg     <= hdr_next;
        ftr_reg     <= ftr_next;
        asz_reg     <= asz_next;
        split_reg   <= split_next;
        res_off_reg <= res_off_next;
        stat_reg    <= stat_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (init_cnt_reg == 3'(INIT_LAST)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_valid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                if (kind_reg == KIND_RELEASE) state_next = ST_LIV_CHK;
                else if (need_reg == WW'(8)) state_next = ST_RESP;
                else state_next = ST_FIT_CHK;
            end
            ST_FIT_CHK: begin
                state_next = (bp_reg < brk_reg) ? ST_FIT_EVAL : ST_GROW;
            end
            ST_FIT_EVAL: begin
                if (rd_sz == '0) state_next = ST_GROW;
                else if (fits) state_next = ST_CRV_W0;
                else state_next = ST_FIT_CHK;
            end
            ST_GROW: begin
                state_next = full ? ST_RESP : ST_GROW_W0;
            end
            ST_GROW_W0: state_next = ST_GROW_W1;
            ST_GROW_W1: state_next = ST_GROW_W2;
            ST_GROW_W2: state_next = ST_MRG_RP;
            ST_MRG_RP:  state_next = ST_MRG_PE;
            ST_MRG_PE:  state_next = ST_MRG_NE;
            ST_MRG_NE: begin
                if (!pfree_reg && rd_alloc)
                    state_next = (kind_reg == KIND_ALLOC) ? ST_CRV_W0 : ST_RESP;
                else
                    state_next = ST_MRG_W0;
            end
            ST_MRG_W0: state_next = ST_MRG_W1;
            ST_MRG_W1: begin
                state_next = (kind_reg == KIND_ALLOC) ? ST_CRV_W0 : ST_RESP;
            end
            ST_CRV_W0: state_next = ST_CRV_W1;
            ST_CRV_W1: state_next = split_reg ? ST_CRV_W2 : ST_RESP;
            ST_CRV_W2: state_next = ST_CRV_W3;
            ST_CRV_W3: state_next = ST_RESP;
            ST_LIV_CHK: begin
                state_next = (bp_reg < brk_reg) ? ST_LIV_EVAL : ST_RESP;
            end
            ST_LIV_EVAL: begin
                if (rd_sz == '0 || bp_reg > off_reg) state_next = ST_RESP;
                else if (bp_reg == off_reg) state_next = rd_alloc ? ST_REL_W0 : ST_RESP;
                else state_next = ST_LIV_CHK;
            end
            ST_REL_W0: state_next = ST_REL_W1;
            ST_REL_W1: state_next = ST_MRG_RP;
            ST_RESP: begin
                if (res_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_comb begin
        init_cnt_next = init_cnt_reg;
        kind_next     = kind_reg;
        need_next     = need_reg;
        off_next      = off_reg;
        bp_next       = bp_reg;
        brk_next      = brk_reg;
        own_next      = own_reg;
        total_next    = total_reg;
        psz_next      = psz_reg;
        pfree_next    = pfree_reg;
        hdr_next      = hdr_reg;
        ftr_next      = ftr_reg;
        asz_next      = asz_reg;
        split_next    = split_reg;
        res_off_next  = res_off_reg;
        stat_next     = stat_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_raddr     = '0;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        case (state_reg)
            ST_INIT: begin
                mem_we        = 1'b1;
                init_cnt_next = init_cnt_reg + 3'd1;
                case (init_cnt_reg)
                    3'd0: begin
                        mem_waddr = WAW'(0);
                        mem_wdata = '0;
                    end
                    3'd1: begin
                        mem_waddr = WAW'(1);
                        mem_wdata = BW'(9);
                    end
                    3'd2: begin
                        mem_waddr = WAW'(2);
                        mem_wdata = BW'(9);
                    end
                    3'd3: begin
                        mem_waddr = WAW'(3);
                        mem_wdata = BW'(INIT_CHUNK);
                    end
                    3'd4: begin
                        mem_waddr = WAW'(INIT_CHUNK / 4 + 2);
                        mem_wdata = BW'(INIT_CHUNK);
                    end
                    default: begin
                        mem_waddr = WAW'(INIT_CHUNK / 4 + 3);
                        mem_wdata = BW'(1);
                    end
                endcase
            end
            ST_IDLE: begin
                in_ready     = 1'b1;
                kind_next    = in_kind;
                need_next    = ((WW'(in_req) + WW'(7)) & ~WW'(7)) + WW'(8);
                off_next     = WW'(in_off);
                bp_next      = WW'(FIRST_PAYLOAD);
                res_off_next = '0;
                stat_next    = STAT_OK;
            end
            ST_DECODE: begin
                if (kind_reg == KIND_ALLOC && need_reg == WW'(8)) stat_next = STAT_ZERO;
            end
            ST_FIT_CHK: begin
                mem_raddr = wa(bp_reg - WW'(4));
            end
            ST_FIT_EVAL: begin
                if (rd_sz != '0) begin
                    if (fits) total_next = rd_sz;
                    else bp_next = bp_reg + rd_sz;
                end
            end
            ST_GROW: begin
                if (full) begin
                    stat_next = STAT_FULL;
                end else begin
                    bp_next  = brk_reg;
                    brk_next = brk_reg + grow;
                    own_next = grow;
                end
            end
            ST_GROW_W0: begin
                mem_we    = 1'b1;
                mem_waddr = wa(bp_reg - WW'(4));
                mem_wdata = BW'(own_reg);
            end
            ST_GROW_W1: begin
                mem_we    = 1'b1;
                mem_waddr = wa(bp_reg + own_reg - WW'(8));
                mem_wdata = BW'(own_reg);
            end
            ST_GROW_W2: begin
                mem_we    = 1'b1;
                mem_waddr = wa(bp_reg + own_reg - WW'(4));
                mem_wdata = BW'(1);
            end
            ST_MRG_RP: begin
                mem_raddr = wa(bp_reg - WW'(8));
            end
            ST_MRG_PE: begin
                pfree_next = !rd_alloc;
                psz_next   = rd_alloc ? '0 : rd_sz;
                mem_raddr  = wa(bp_reg + own_reg - WW'(4));
            end
            ST_MRG_NE: begin
                total_next = own_reg + psz_reg + nsz;
                hdr_next   = bp_reg - psz_reg - WW'(4);
                ftr_next   = bp_reg + own_reg + nsz - WW'(8);
                bp_next    = bp_reg - psz_reg;
            end
            ST_MRG_W0: begin
                mem_we    = 1'b1;
                mem_waddr = wa(hdr_reg);
                mem_wdata = BW'(total_reg);
            end
            ST_MRG_W1: begin
                mem_we    = 1'b1;
                mem_waddr = wa(ftr_reg);
                mem_wdata = BW'(total_reg);
            end
            ST_CRV_W0: begin
                split_next = split_now;
                asz_next   = split_now ? need_reg : total_reg;
                mem_we     = 1'b1;
                mem_waddr  = wa(bp_reg - WW'(4));
                mem_wdata  = BW'(split_now ? need_reg : total_reg) | BW'(1);
            end
            ST_CRV_W1: begin
                mem_we       = 1'b1;
                mem_waddr    = wa(bp_reg + asz_reg - WW'(8));
                mem_wdata    = BW'(asz_reg) | BW'(1);
                res_off_next = bp_reg[OFF_W-1:0];
            end
            ST_CRV_W2: begin
                mem_we    = 1'b1;
                mem_waddr = wa(bp_reg + asz_reg - WW'(4));
                mem_wdata = BW'(total_reg - asz_reg);
            end
            ST_CRV_W3: begin
                mem_we    = 1'b1;
                mem_waddr = wa(bp_reg + total_reg - WW'(8));
                mem_wdata = BW'(total_reg - asz_reg);
            end
            ST_LIV_CHK: begin
                mem_raddr = wa(bp_reg - WW'(4));
            end
            ST_LIV_EVAL: begin
                if (rd_sz != '0 && bp_reg <= off_reg) begin
                    if (bp_reg == off_reg) own_next = rd_sz;
                    else bp_next = bp_reg + rd_sz;
                end
            end
            ST_REL_W0: begin
                mem_we    = 1'b1;
                mem_waddr = wa(bp_reg - WW'(4));
                mem_wdata = BW'(own_reg);
            end
            ST_REL_W1: begin
                mem_we    = 1'b1;
                mem_waddr = wa(bp_reg + own_reg - WW'(8));
                mem_wdata = BW'(own_reg);
            end
            ST_RESP: begin
                res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign res_off  = res_off_reg;
    assign res_stat = stat_reg;

endmodule

// File: src/boundary_tag_first_fit_allocator.sv
// Top level of the boundary-tag first-fit heap allocator.
// Each block visited in the first-fit or release walk takes a read on the tag memory read port,
// followed as needed by heap growth, coalescing and splitting.
// Throughput: one word at a time; s_tready is high only while the sequencer is idle.
// Reset: initial tag writes to words 0-3, 1026 and 1027, break at 4112; other tag words are not cleared.
`timescale 1ns / 1ps

module boundary_tag_first_fit_allocator #(
    parameter int HEAP_WORDS  = 65536,
    parameter int CHUNK_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // req_bytes[18:0], release_offset[36:19], zero pad
    input  logic [0:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // payload_offset[17:0], status[19:18], zero pad
);

    import bta_pkg::*;

    localparam int WAW = $clog2(HEAP_WORDS);
    localparam int BW  = WAW + 3;

    logic              res_valid;
    logic              res_ready;
    logic [OFF_W-1:0]  res_off;
    logic [STAT_W-1:0] res_stat;
    logic              mem_we;
    logic [WAW-1:0]    mem_waddr;
    logic [BW-1:0]     mem_wdata;
    logic [WAW-1:0]    mem_raddr;
    logic [BW-1:0]     mem_rdata;

    logic              m_valid_reg;
    logic [OFF_W-1:0]  m_off_reg;
    logic [STAT_W-1:0] m_stat_reg;

    bta_seq #(
        .HEAP_WORDS (HEAP_WORDS),
        .CHUNK_BYTES(CHUNK_BYTES),
        .WAW        (WAW),
        .BW         (BW)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (s_tuser[0]),
        .in_req   (s_tdata[18:0]),
        .in_off   (s_tdata[36:19]),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_off  (res_off),
        .res_stat (res_stat),
        .mem_we   (mem_we),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata),
        .mem_raddr(mem_raddr),
        .mem_rdata(mem_rdata)
    );

    bta_tag_ram #(
        .DEPTH(HEAP_WORDS),
        .AW   (WAW),
        .DW   (BW)
    ) u_ram (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_off_reg  <= res_off;
            m_stat_reg <= res_stat;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_stat_reg, m_off_reg};

endmodule
